// ===== rtl/rrts_pkg.sv =====
`default_nettype none
package rrts_pkg;

	localparam int SLOT_COUNT    = 16;
	localparam int SLOT_W        = $clog2(SLOT_COUNT);
	localparam int CNT_W         = $clog2(SLOT_COUNT + 1);
	localparam int ID_W          = 32;
	localparam int TICK_W        = 64;
	localparam int MS_W          = 32;
	localparam int SLICE_W       = 16;
	localparam int TPS_W         = 14;
	localparam int CFG_DATA_W    = 16;
	localparam int CFG_IDX_W     = 1;
	localparam int PROD_W        = MS_W + TPS_W;
	localparam int MUL_W         = 32;
	localparam int DIV_STEPS     = 4;
	localparam int DIV_CNT_W     = 2;
	localparam int REM_W         = 10;
	localparam int MS_PER_SECOND = 1000;
	// x / 1000 == (x * RECIP_MS) >> RECIP_SHIFT for every 32-bit x
	localparam logic [MUL_W-1:0] RECIP_MS = 32'h10624DD3;
	localparam int RECIP_SHIFT   = 38;

	localparam logic [CFG_IDX_W-1:0] CFG_SLICE_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SEC = 1'd1;

	typedef enum logic [2:0] {
		ST_EMPTY    = 3'd0,
		ST_READY    = 3'd1,
		ST_RUNNING  = 3'd2,
		ST_SLEEPING = 3'd3,
		ST_DEAD     = 3'd4
	} slot_st_t;

	typedef enum logic [2:0] {
		K_SCHEDULE = 3'd0,
		K_YIELD    = 3'd1,
		K_WAKE     = 3'd2,
		K_CREATE   = 3'd3,
		K_KILL     = 3'd4,
		K_SLEEP    = 3'd5,
		K_EXIT     = 3'd6,
		K_NONE     = 3'd7
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WAKE,
		S_CREATE,
		S_KILL,
		S_MUL,
		S_DIV,
		S_ADD,
		S_SCHK,
		S_SCHED,
		S_LIVE,
		S_DONE
	} fsm_t;

endpackage
`default_nettype wire

// ===== rtl/round_robin_task_table_scheduler_core.sv =====
`default_nettype none
// round-robin task table for one cpu. each request (schedule, yield, wake expired, create,
// kill, sleep, exit) is run by a small sequencer that walks the slot table one slot per
// cycle through a single shared compare path, then walks it once more to count live
// tasks, and returns one result. sleep first adds the millisecond to tick conversion, a
// reciprocal divide by 1000 on one shared 32x32 multiplier. in_ready is high only while
// the sequencer is idle; a finished result waits in the output register and the next
// request can be taken meanwhile.
// configuration writes land at once and are meant for idle periods only.
module round_robin_task_table_scheduler_core
	import rrts_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [2:0]            kind,
	input  wire logic [TICK_W-1:0]     now_tick,
	input  wire logic [ID_W-1:0]       target_id,
	input  wire logic [MS_W-1:0]       sleep_ms,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       status,
	output logic [ID_W-1:0]            created_id,
	output logic                       switched,
	output logic [SLOT_W-1:0]          running_slot,
	output logic [ID_W-1:0]            running_id,
	output logic [CNT_W-1:0]           live_count
);

	// configuration
	logic [SLICE_W-1:0] slice_len_q;
	logic [TPS_W-1:0]   tps_q;

	// slot table
	slot_st_t          slot_st_q [SLOT_COUNT];
	logic [ID_W-1:0]   slot_id_q [SLOT_COUNT];
	logic [TICK_W-1:0] slot_wake_q [SLOT_COUNT];

	logic [CNT_W-1:0]   hw_q;
	logic [ID_W-1:0]    next_id_q;
	logic [SLOT_W-1:0]  cur_q;
	logic [SLICE_W:0]   slice_q;

	// sequencer
	fsm_t state_q, nxt_state;
	logic [SLOT_W-1:0]  idx_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   live_acc_q;

	// captured request
	kind_t              kind_q;
	logic [TICK_W-1:0]  now_q;
	logic [ID_W-1:0]    target_q;
	logic [MS_W-1:0]    ms_q;

	// result scratch
	logic               res_status_q;
	logic [ID_W-1:0]    res_created_q;
	logic               res_sw_q;

	// millisecond to tick conversion on one shared multiplier
	logic [MUL_W-1:0]     mul_a;
	logic [MUL_W-1:0]     mul_b;
	logic [2*MUL_W-1:0]   mul_p;
	logic [MS_W-1:0]      ms_quo_q;
	logic [REM_W-1:0]     ms_rem_q;
	logic [PROD_W-1:0]    whole_q;
	logic [MUL_W-1:0]     frac_q;
	logic [PROD_W-1:0]    ticks_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	// shared scan path
	slot_st_t          st;
	slot_st_t          cur_st;
	logic              last;
	logic [CNT_W-1:0]  idx_inc;
	logic [SLOT_W-1:0] idx_circ;
	logic [CNT_W-1:0]  cur_inc;
	logic [SLOT_W-1:0] cur_circ;
	logic [SLICE_W:0]  slice_inc;
	logic              keep_slice;
	logic              create_take;
	logic              kill_hit;
	logic              wake_hit;
	logic              live_hit;
	logic [TICK_W-1:0] ticks;
	logic              out_free;

	assign st      = slot_st_q[idx_q];
	assign cur_st  = slot_st_q[cur_q];
	assign last    = (cnt_q == hw_q - 1'b1);
	assign idx_inc = {1'b0, idx_q} + 1'b1;
	assign idx_circ = (idx_inc == hw_q) ? '0 : idx_inc[SLOT_W-1:0];
	assign cur_inc = {1'b0, cur_q} + 1'b1;
	assign cur_circ = (cur_inc == hw_q) ? '0 : cur_inc[SLOT_W-1:0];

	// a running task under plain schedule keeps the cpu until its slice is used
	assign slice_inc  = slice_q + 1'b1;
	assign keep_slice = (cur_st == ST_RUNNING) && (kind_q == K_SCHEDULE)
		&& (slice_inc < {1'b0, slice_len_q});

	// first dead slot, or the fresh slot at the high-water mark
	assign create_take = (st == ST_DEAD) || (cnt_q == hw_q);
	assign kill_hit    = (slot_id_q[idx_q] == target_q) && (st != ST_DEAD);
	assign wake_hit    = (st == ST_SLEEPING) && (now_q >= slot_wake_q[idx_q]);
	assign live_hit    = (st != ST_EMPTY) && (st != ST_DEAD);

	// ms * tps / 1000 split as (ms / 1000) * tps + ((ms % 1000) * tps) / 1000
	always_comb begin
		mul_a = ms_q;
		mul_b = RECIP_MS;
		if (state_q == S_DIV) begin
			case (div_cnt_q)
				2'd0: begin
					mul_a = ms_quo_q;
					mul_b = MUL_W'(MS_PER_SECOND);
				end
				2'd1: begin
					mul_a = ms_quo_q;
					mul_b = {{(MUL_W-TPS_W){1'b0}}, tps_q};
				end
				2'd2: begin
					mul_a = {{(MUL_W-REM_W){1'b0}}, ms_rem_q};
					mul_b = {{(MUL_W-TPS_W){1'b0}}, tps_q};
				end
				default: begin
					mul_a = frac_q;
					mul_b = RECIP_MS;
				end
			endcase
		end
	end

	assign mul_p = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

	// a nonzero sleep never rounds down to zero ticks
	assign ticks = ((ticks_q == '0) && (ms_q != '0)) ? TICK_W'(1)
		: {{(TICK_W-PROD_W){1'b0}}, ticks_q};

	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= nxt_state;
		end
	end

	always_comb begin
		nxt_state = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (kind_t'(kind))
						K_SCHEDULE, K_YIELD, K_EXIT: nxt_state = S_SCHK;
						K_WAKE:   nxt_state = S_WAKE;
						K_CREATE: nxt_state = (hw_q == CNT_W'(SLOT_COUNT)) ? S_LIVE : S_CREATE;
						K_KILL:   nxt_state = (hw_q == CNT_W'(1)) ? S_LIVE : S_KILL;
						K_SLEEP:  nxt_state = S_MUL;
						default:  nxt_state = S_LIVE;
					endcase
				end
			end
			S_WAKE:   if (last) nxt_state = S_LIVE;
			S_CREATE: if (create_take) nxt_state = S_LIVE;
			S_KILL:   if (kill_hit || last) nxt_state = S_LIVE;
			S_MUL:    nxt_state = S_DIV;
			S_DIV:    if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) nxt_state = S_ADD;
			S_ADD:    nxt_state = S_SCHK;
			S_SCHK:   nxt_state = keep_slice ? S_LIVE : S_SCHED;
			S_SCHED:  if ((st == ST_READY) || last) nxt_state = S_LIVE;
			S_LIVE:   if (last) nxt_state = S_DONE;
			S_DONE:   if (out_free) nxt_state = S_IDLE;
			default:  nxt_state = S_IDLE;
		endcase
	end

	// control state and the part of the table with a known reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_st_q[i] <= ST_EMPTY;
				slot_id_q[i] <= '0;
			end
			slot_st_q[0] <= ST_RUNNING;
			slice_len_q  <= SLICE_W'(10);
			tps_q        <= TPS_W'(1000);
			hw_q         <= CNT_W'(1);
			next_id_q    <= ID_W'(1);
			cur_q        <= '0;
			slice_q      <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					CFG_SLICE_LENGTH:  slice_len_q <= cfg_data[SLICE_W-1:0];
					CFG_TICKS_PER_SEC: tps_q <= cfg_data[TPS_W-1:0];
					default: ;
				endcase
			end
			// a new result loads as the old one leaves
			if ((state_q == S_DONE) && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && (kind_t'(kind) == K_EXIT)) begin
						slot_st_q[cur_q] <= ST_DEAD;
					end
				end
				S_WAKE: begin
					if (wake_hit) slot_st_q[idx_q] <= ST_READY;
				end
				S_CREATE: begin
					if (create_take) begin
						slot_st_q[idx_q] <= ST_READY;
						slot_id_q[idx_q] <= next_id_q;
						next_id_q <= next_id_q + 1'b1;
						if (cnt_q == hw_q) hw_q <= hw_q + 1'b1;
					end
				end
				S_KILL: begin
					if (kill_hit) slot_st_q[idx_q] <= ST_DEAD;
				end
				S_ADD: begin
					slot_st_q[cur_q] <= ST_SLEEPING;
				end
				S_SCHK: begin
					slice_q <= keep_slice ? slice_inc : '0;
				end
				S_SCHED: begin
					if (st == ST_READY) begin
						if (cur_st == ST_RUNNING) slot_st_q[cur_q] <= ST_READY;
						slot_st_q[idx_q] <= ST_RUNNING;
						cur_q    <= idx_q;
					end
				end
				default: ;
			endcase
		end
	end

	// payload and scratch registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					kind_q        <= kind_t'(kind);
					now_q         <= now_tick;
					target_q      <= target_id;
					ms_q          <= sleep_ms;
					res_created_q <= '0;
					res_sw_q      <= 1'b0;
					// a full table or an empty kill range fails at once
					res_status_q  <= ((kind_t'(kind) == K_CREATE) && (hw_q == CNT_W'(SLOT_COUNT)))
						|| ((kind_t'(kind) == K_KILL) && (hw_q == CNT_W'(1)));
				end
			end
			S_CREATE: begin
				if (create_take) begin
					res_created_q    <= next_id_q;
				end
			end
			S_KILL: begin
				if (!kill_hit && last) res_status_q <= 1'b1;
			end
			S_MUL: begin
				ms_quo_q  <= MS_W'(mul_p[2*MUL_W-1:RECIP_SHIFT]);
				div_cnt_q <= '0;
			end
			S_DIV: begin
				case (div_cnt_q)
					2'd0: ms_rem_q <= REM_W'(ms_q - mul_p[MS_W-1:0]);
					2'd1: whole_q <= mul_p[PROD_W-1:0];
					2'd2: frac_q <= mul_p[MUL_W-1:0];
					default: ticks_q <= whole_q + PROD_W'(mul_p[2*MUL_W-1:RECIP_SHIFT]);
				endcase
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			S_ADD: begin
				slot_wake_q[cur_q] <= now_q + ticks;
			end
			S_SCHED: begin
				if (st == ST_READY) res_sw_q <= 1'b1;
			end
			S_LIVE: begin
				if (live_hit) live_acc_q <= live_acc_q + 1'b1;
			end
			S_DONE: begin
				if (out_free) begin
					status       <= res_status_q;
					created_id   <= res_created_q;
					switched     <= res_sw_q;
					running_slot <= cur_q;
					running_id   <= slot_id_q[cur_q];
					live_count   <= live_acc_q;
				end
			end
			default: ;
		endcase

		// scan position: set on entry to a walk, else step
		if (state_q != nxt_state) begin
			case (nxt_state)
				S_KILL: begin
					idx_q <= SLOT_W'(1);
					cnt_q <= CNT_W'(1);
				end
				S_SCHED: begin
					idx_q <= cur_circ;
					cnt_q <= '0;
				end
				default: begin
					idx_q <= '0;
					cnt_q <= '0;
				end
			endcase
			if (nxt_state == S_LIVE) live_acc_q <= '0;
		end else begin
			idx_q <= (state_q == S_SCHED) ? idx_circ : idx_inc[SLOT_W-1:0];
			cnt_q <= cnt_q + 1'b1;
		end
	end

	a_cur_below_hw: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q < SLOT_W'(hw_q - 1'b1) || {1'b0, cur_q} == hw_q - 1'b1)
		else $error("current slot beyond high-water mark");

	a_hw_range: assert property (@(posedge clk) disable iff (!arst_n)
		hw_q != '0 && hw_q <= CNT_W'(SLOT_COUNT))
		else $error("high-water mark out of range");

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != S_IDLE)
		else $error("request accepted but sequencer stayed idle");

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> live_acc_q <= hw_q)
		else $error("live count above high-water mark");

endmodule
`default_nettype wire
